>>> hw/rtl/bicc_pkg.sv
// ----------------------------------------------------------------------------
// bicc_pkg
// Shared widths, codes, command and status types and wall tables for the
// beam index coordinate converter.
// ----------------------------------------------------------------------------
package bicc_pkg;

    localparam int GRID_W    = 7;
    localparam int AREA_W    = 13;
    localparam int SUM_W     = 15;
    localparam int IDX_W     = 29;
    localparam int WALL_W    = 3;
    localparam int CELL_W    = 6;
    localparam int NWALL     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 64;

    localparam int MAX_GRID_DEF = 64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

    localparam logic ACT_DECODE = 1'b0;
    localparam logic ACT_ENCODE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_AREA, S_BASE, S_PREP, S_DW0, S_DW1,
        S_DQ_ST, S_DQ_WT, S_DV0_ST, S_DV0_WT, S_DV1_ST, S_DV1_WT,
        S_E1, S_E2, S_E3, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_BASE_INIT, OP_BASE, OP_PREP, OP_DW0, OP_DW1,
        OP_DQ_START, OP_DQ_TAKE, OP_DV0_START, OP_DV0_TAKE,
        OP_DV1_START, OP_DV1_TAKE, OP_E1, OP_E2, OP_E3, OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic cfg_we;
    } t_cmd;

    typedef struct packed {
        logic is_enc;
        logic ok;
        logic w0_found;
        logic w1_found;
        logic base_last;
        logic div_done;
    } t_status;

    // Column axis of each wall.
    function automatic logic [1:0] wall_col(input logic [WALL_W-1:0] w);
        case (w)
            3'd0, 3'd1: wall_col = 2'd1;
            3'd2, 3'd3: wall_col = 2'd2;
            default:    wall_col = 2'd0;
        endcase
    endfunction

    // Row axis of each wall.
    function automatic logic [1:0] wall_row(input logic [WALL_W-1:0] w);
        case (w)
            3'd0, 3'd1: wall_row = 2'd2;
            3'd2, 3'd3: wall_row = 2'd0;
            default:    wall_row = 2'd1;
        endcase
    endfunction

endpackage

>>> hw/rtl/bicc_div.sv
// ----------------------------------------------------------------------------
// bicc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bicc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [bicc_pkg::IDX_W-1:0]   i_dividend,
    input  logic [bicc_pkg::AREA_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [bicc_pkg::IDX_W-1:0]   o_quotient,
    output logic [bicc_pkg::AREA_W-1:0]  o_remainder
);
    import bicc_pkg::*;

    localparam logic [4:0] LAST = 5'(IDX_W - 1);

    logic              r_busy, r_done;
    logic [4:0]        r_cnt;
    logic [IDX_W-1:0]  r_quo;
    logic [AREA_W-1:0] r_rem, r_dvs, n_rem;
    logic [AREA_W:0]   rem_sh, diff;
    logic              ge;

    assign rem_sh = {r_rem, r_quo[IDX_W-1]};
    assign diff   = rem_sh - {1'b0, r_dvs};
    assign ge     = rem_sh >= {1'b0, r_dvs};
    assign n_rem  = ge ? diff[AREA_W-1:0] : rem_sh[AREA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == LAST) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_rem <= n_rem;
            r_quo <= {r_quo[IDX_W-2:0], ge};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

>>> hw/rtl/bicc_datapath.sv
// ----------------------------------------------------------------------------
// bicc_datapath
// Grid registers, wall areas and bases, decode search, encode arithmetic
// and the output word register.
// ----------------------------------------------------------------------------
module bicc_datapath #(
    parameter int MAX_GRID = bicc_pkg::MAX_GRID_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bicc_pkg::t_cmd                  i_cmd,
    output bicc_pkg::t_status               o_st,
    input  logic [bicc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bicc_pkg::GRID_W-1:0]     i_cfg_data,
    input  logic [bicc_pkg::TDATA_W-1:0]    i_s_tdata,
    input  logic                            i_s_tuser,
    output logic [bicc_pkg::TDATA_W-1:0]    o_m_tdata,
    output logic                            o_m_tuser
);
    import bicc_pkg::*;

    localparam logic [GRID_W-1:0] MAX_G = GRID_W'(MAX_GRID);

    logic [GRID_W-1:0] r_grid [3];
    logic [AREA_W-1:0] r_area [NWALL];
    logic [IDX_W-1:0]  r_base [NWALL];
    logic [2:0]        r_bw;

    logic              r_act, r_ok, r_rev;
    logic [IDX_W-1:0]  r_idx, r_i, r_n, r_out_idx;
    logic [WALL_W-1:0] r_wa, r_wb, r_w0, r_w1, r_j;
    logic [CELL_W-1:0] r_ua, r_va, r_ub, r_vb, r_u0, r_v0, r_u1, r_v1;
    logic [AREA_W-1:0] r_i2, r_t0, r_t1;
    logic [SUM_W-1:0]  r_sum;
    logic [27:0]       r_p0;
    logic [25:0]       r_p1;

    logic [TDATA_W-1:0] r_o_data;
    logic               r_o_user;

    logic [GRID_W-1:0] cfg_v;
    logic [2:0]        bw_m1, j_p1;
    logic [SUM_W-1:0]  sfx, esum;
    logic [27:0]       bprod;
    logic [IDX_W-1:0]  base_nx, top, top_m1, base_w0;
    logic [IDX_W:0]    nb;
    logic [AREA_W-1:0] area_w0, area_w1;
    logic [GRID_W-1:0] col_w0, col_w1;
    logic [25:0]       n_pair;
    logic              found0, found1;
    logic [WALL_W-1:0] s_w0, s_w1;
    logic [31:0]       eidx;

    logic              div_start, div_done;
    logic [IDX_W-1:0]  div_dvd, div_quo;
    logic [AREA_W-1:0] div_dvs, div_rem;

    always_comb begin
        cfg_v = i_cfg_data;
        if (cfg_v == '0) cfg_v = GRID_W'(1);
        else if (cfg_v > MAX_G) cfg_v = MAX_G;
    end

    // Suffix sum of areas from the wall being derived upwards.
    always_comb begin
        sfx = '0;
        for (int k = 0; k < NWALL; k++) begin
            if (3'(k) >= r_bw) sfx = sfx + SUM_W'(r_area[k]);
        end
    end
    assign bw_m1   = r_bw - 3'd1;
    assign bprod   = r_area[bw_m1] * sfx;
    assign base_nx = r_base[bw_m1] + IDX_W'(bprod);

    assign area_w0 = (r_w0 < 3'(NWALL)) ? r_area[r_w0] : '0;
    assign area_w1 = (r_w1 < 3'(NWALL)) ? r_area[r_w1] : '0;
    assign base_w0 = (r_w0 < 3'(NWALL)) ? r_base[r_w0] : '0;
    assign col_w0  = r_grid[wall_col(r_w0)];
    assign col_w1  = r_grid[wall_col(r_w1)];

    assign top    = r_base[NWALL-1];
    assign top_m1 = top - IDX_W'(1);
    assign nb     = {top_m1, 1'b0};

    assign j_p1   = r_j + 3'd1;
    assign found0 = (r_base[j_p1] > r_i) || (r_j == 3'd4);
    assign n_pair = r_area[r_w0] * r_area[r_j];
    assign found1 = (r_j == 3'd5) || (IDX_W'(n_pair) > r_i);

    assign s_w0 = (r_wa > r_wb) ? r_wb : r_wa;
    assign s_w1 = (r_wa > r_wb) ? r_wa : r_wb;

    always_comb begin
        esum = '0;
        for (int k = 0; k < NWALL; k++) begin
            if (3'(k) > r_w0 && 3'(k) < r_w1) esum = esum + SUM_W'(r_area[k]);
        end
    end

    assign eidx = 32'(r_p0) + 32'(base_w0) + 32'(r_p1) + 32'(r_t1)
                + (r_rev ? 32'(top_m1) : 32'd0);

    always_comb begin
        div_start = 1'b0;
        div_dvd   = r_i;
        div_dvs   = area_w1;
        case (i_cmd.op)
            OP_DQ_START: div_start = 1'b1;
            OP_DV0_START: begin
                div_start = 1'b1;
                div_dvd   = r_n;
                div_dvs   = AREA_W'(col_w0);
            end
            OP_DV1_START: begin
                div_start = 1'b1;
                div_dvd   = IDX_W'(r_i2);
                div_dvs   = AREA_W'(col_w1);
            end
            default: ;
        endcase
    end

    bicc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (div_dvs),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Configuration state: grid counts, areas and wall bases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) r_grid[k] <= GRID_W'(1);
            for (int k = 0; k < NWALL; k++) r_area[k] <= AREA_W'(1);
            r_base[0] <= IDX_W'(1);
            r_base[1] <= IDX_W'(6);
            r_base[2] <= IDX_W'(10);
            r_base[3] <= IDX_W'(13);
            r_base[4] <= IDX_W'(15);
            r_base[5] <= IDX_W'(16);
            r_bw      <= 3'd1;
        end else begin
            if (i_cmd.cfg_we) begin
                unique case (i_cfg_index)
                    REG_GRID_X: r_grid[0] <= cfg_v;
                    REG_GRID_Y: r_grid[1] <= cfg_v;
                    REG_GRID_Z: r_grid[2] <= cfg_v;
                    default: ;
                endcase
            end
            for (int k = 0; k < NWALL; k++) begin
                r_area[k] <= AREA_W'(r_grid[wall_col(3'(k))])
                           * AREA_W'(r_grid[wall_row(3'(k))]);
            end
            if (i_cmd.op == OP_BASE_INIT) r_bw <= 3'd1;
            if (i_cmd.op == OP_BASE) begin
                r_base[r_bw] <= base_nx;
                r_bw         <= r_bw + 3'd1;
            end
        end
    end

    // Working registers of one word.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_act <= i_s_tuser;
                r_idx <= i_s_tdata[28:0];
                r_wa  <= i_s_tdata[31:29];
                r_ua  <= i_s_tdata[37:32];
                r_va  <= i_s_tdata[43:38];
                r_wb  <= i_s_tdata[46:44];
                r_ub  <= i_s_tdata[52:47];
                r_vb  <= i_s_tdata[58:53];
            end
            OP_PREP: begin
                r_j <= 3'd0;
                if (r_act) begin
                    r_ok  <= (r_wa != r_wb) && (s_w1 < 3'(NWALL));
                    r_rev <= r_wa > r_wb;
                    r_w0  <= s_w0;
                    r_w1  <= s_w1;
                    r_u0  <= (r_wa > r_wb) ? r_ub : r_ua;
                    r_v0  <= (r_wa > r_wb) ? r_vb : r_va;
                    r_u1  <= (r_wa > r_wb) ? r_ua : r_ub;
                    r_v1  <= (r_wa > r_wb) ? r_va : r_vb;
                end else begin
                    r_ok  <= (r_idx != '0) && ({1'b0, r_idx} <= nb);
                    r_rev <= r_idx >= top;
                    r_i   <= (r_idx >= top) ? (r_idx - top_m1) : r_idx;
                end
            end
            OP_DW0: begin
                if (found0) begin
                    r_w0 <= r_j;
                    r_i  <= r_i - r_base[r_j];
                end
                r_j <= j_p1;
            end
            OP_DW1: begin
                if (found1) begin
                    r_w1 <= r_j;
                end else begin
                    r_i <= r_i - IDX_W'(n_pair);
                    r_j <= j_p1;
                end
            end
            OP_DQ_TAKE: begin
                r_n  <= div_quo;
                r_i2 <= div_rem;
            end
            OP_DV0_TAKE: begin
                r_v0 <= div_quo[CELL_W-1:0];
                r_u0 <= div_rem[CELL_W-1:0];
            end
            OP_DV1_TAKE: begin
                r_v1 <= div_quo[CELL_W-1:0];
                r_u1 <= div_rem[CELL_W-1:0];
            end
            OP_E1: begin
                r_sum <= esum;
                r_t0  <= AREA_W'(col_w0) * AREA_W'(r_v0) + AREA_W'(r_u0);
                r_t1  <= AREA_W'(col_w1) * AREA_W'(r_v1) + AREA_W'(r_u1);
            end
            OP_E2: begin
                r_p0 <= r_sum * area_w0;
                r_p1 <= r_t0 * area_w1;
            end
            OP_E3: r_out_idx <= eidx[IDX_W-1:0];
            default: ;
        endcase
    end

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_EMIT) begin
            r_o_user <= r_ok;
            if (!r_ok) begin
                r_o_data <= '0;
            end else if (r_act) begin
                r_o_data <= TDATA_W'(r_out_idx);
            end else if (r_rev) begin
                r_o_data <= {5'b0, r_v0, r_u0, r_w0, r_v1, r_u1, r_w1, 29'b0};
            end else begin
                r_o_data <= {5'b0, r_v1, r_u1, r_w1, r_v0, r_u0, r_w0, 29'b0};
            end
        end
    end

    assign o_m_tdata = r_o_data;
    assign o_m_tuser = r_o_user;

    assign o_st.is_enc    = r_act;
    assign o_st.ok        = r_ok;
    assign o_st.w0_found  = found0;
    assign o_st.w1_found  = found1;
    assign o_st.base_last = (r_bw == 3'(NWALL - 1));
    assign o_st.div_done  = div_done;

endmodule

>>> hw/rtl/bicc_ctrl.sv
// ----------------------------------------------------------------------------
// bicc_ctrl
// Sequencer for configuration updates, decode and encode, plus the output
// word valid flag.
// ----------------------------------------------------------------------------
module bicc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  bicc_pkg::t_status  i_st,
    output bicc_pkg::t_cmd     o_cmd
);
    import bicc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_out_valid && !i_m_tready) || emit;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.cfg_we  = 1'b0;
        o_cfg_ready   = 1'b0;
        o_s_tready    = 1'b0;
        emit          = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cfg_ready = 1'b1;
                o_s_tready  = !i_cfg_valid;
                if (i_cfg_valid) begin
                    o_cmd.cfg_we = 1'b1;
                    n_state      = S_AREA;
                end else if (i_s_tvalid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_AREA: begin
                o_cmd.op = OP_BASE_INIT;
                n_state  = S_BASE;
            end
            S_BASE: begin
                o_cmd.op = OP_BASE;
                if (i_st.base_last) n_state = S_IDLE;
            end
            S_PREP: begin
                o_cmd.op = OP_PREP;
                n_state  = i_st.is_enc ? S_E1 : S_DW0;
            end
            S_DW0: begin
                if (!i_st.ok) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_DW0;
                    if (i_st.w0_found) n_state = S_DW1;
                end
            end
            S_DW1: begin
                o_cmd.op = OP_DW1;
                if (i_st.w1_found) n_state = S_DQ_ST;
            end
            S_DQ_ST: begin
                o_cmd.op = OP_DQ_START;
                n_state  = S_DQ_WT;
            end
            S_DQ_WT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_DQ_TAKE;
                    n_state  = S_DV0_ST;
                end
            end
            S_DV0_ST: begin
                o_cmd.op = OP_DV0_START;
                n_state  = S_DV0_WT;
            end
            S_DV0_WT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_DV0_TAKE;
                    n_state  = S_DV1_ST;
                end
            end
            S_DV1_ST: begin
                o_cmd.op = OP_DV1_START;
                n_state  = S_DV1_WT;
            end
            S_DV1_WT: begin
                if (i_st.div_done) begin
                    o_cmd.op = OP_DV1_TAKE;
                    n_state  = S_DONE;
                end
            end
            S_E1: begin
                o_cmd.op = OP_E1;
                n_state  = S_E2;
            end
            S_E2: begin
                o_cmd.op = OP_E2;
                n_state  = S_E3;
            end
            S_E3: begin
                o_cmd.op = OP_E3;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // The previous word must have gone before this one is loaded.
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.op = OP_EMIT;
                    emit     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule

>>> hw/rtl/beam_index_coordinate_convert.sv
// ----------------------------------------------------------------------------
// beam_index_coordinate_convert
// Converts between beam indices and pairs of wall cells in a gridded box.
// ----------------------------------------------------------------------------
// Decode runs set-up, the wall searches, three serial divisions in the shared
// divider and the output load; an out-of-range index skips to the output load.
// Encode runs set-up, its arithmetic steps and the output load. One word is in
// work at a time and the next is accepted in the cycle after a result is loaded,
// unless a register write is waiting. A register write blocks the input while
// the bases are rederived; synchronous active-low reset sets grids to 1.
module beam_index_coordinate_convert #(
    parameter int MAX_GRID = bicc_pkg::MAX_GRID_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bicc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bicc_pkg::GRID_W-1:0]     i_cfg_data,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // beam_index[28:0], wall_a[31:29], a_u[37:32], a_v[43:38],
    // wall_b[46:44], b_u[52:47], b_v[58:53], zeros above
    input  logic [bicc_pkg::TDATA_W-1:0]    i_s_axis_tdata,
    // action
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // index_out[28:0], wall_first[31:29], first_u[37:32], first_v[43:38],
    // wall_second[46:44], second_u[52:47], second_v[58:53], zeros above
    output logic [bicc_pkg::TDATA_W-1:0]    o_m_axis_tdata,
    // ok
    output logic                            o_m_axis_tuser
);
    import bicc_pkg::*;

    t_cmd    cmd;
    t_status st;

    bicc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    bicc_datapath #(
        .MAX_GRID (MAX_GRID)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser)
    );

endmodule

>>> sim/beam_index_coordinate_convert_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beam_index_coordinate_convert_checker
// Watches the configuration, input and output channels of the converter,
// keeps its own grid counts and wall bases, predicts each result word and
// compares it and its ok flag as a whole with what the block returns.
// ----------------------------------------------------------------------------
module beam_index_coordinate_convert_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [bicc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bicc_pkg::GRID_W-1:0]    i_cfg_data,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [bicc_pkg::TDATA_W-1:0]   i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [bicc_pkg::TDATA_W-1:0]   i_m_tdata,
    input  logic                           i_m_tuser,
    output int                             o_fail_count,
    output int                             o_pending
);
    import bicc_pkg::*;

    typedef struct packed {
        logic       ok;
        logic [63:0] data;
    } t_conv;

    t_conv       conv_queue[$];
    logic [31:0] grid[3];
    logic [31:0] wall_base[6];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = conv_queue.size();

    function automatic logic [1:0] axis_col(int w);
        return (w < 2) ? 2'd1 : (w < 4) ? 2'd2 : 2'd0;
    endfunction

    function automatic logic [1:0] axis_row(int w);
        return (w < 2) ? 2'd2 : (w < 4) ? 2'd0 : 2'd1;
    endfunction

    function automatic logic [31:0] wall_area(int w);
        return grid[axis_col(w)] * grid[axis_row(w)];
    endfunction

    task automatic rebuild_bases();
        logic [63:0] acc;
        wall_base[0] = 1;
        for (int w = 1; w < 6; w++) begin
            acc = 0;
            for (int k = w; k < 6; k++) acc += 64'(wall_area(k));
            acc = acc * 64'(wall_area(w - 1)) + 64'(wall_base[w - 1]);
            wall_base[w] = 32'(acc[28:0]);
        end
    endtask

    function automatic t_conv convert_word(logic action, logic [63:0] d);
        t_conv       r;
        logic [31:0] top, nb, i, n, n2, col, u0, v0, u1, v1;
        logic [63:0] acc, a_u, a_v, b_u, b_v, ua, va, ub, vb;
        int          w0, w1, j, wa, wb;
        logic        rev;
        r = '0;
        if (action == ACT_DECODE) begin
            top = wall_base[5];
            nb  = (top - 1) * 2;
            i   = {3'b0, d[28:0]};
            if (i < 1 || i > nb) return r;
            rev = i >= top;
            if (rev) i -= top - 1;
            for (j = 0; j < 5; j++) if (wall_base[j + 1] > i) break;
            w0 = j;
            i -= wall_base[w0];
            n2 = wall_area(w0);
            while (++j < 5) begin
                n = n2 * wall_area(j);
                if (n > i) break;
                i -= n;
            end
            w1  = j;
            n2  = wall_area(w1);
            n   = i / n2;
            col = grid[axis_col(w0)];
            v0  = n / col;
            u0  = n - v0 * col;
            i  -= n * n2;
            col = grid[axis_col(w1)];
            v1  = i / col;
            u1  = i - v1 * col;
            r.ok = 1'b1;
            if (rev)
                r.data = {5'b0, v0[5:0], u0[5:0], 3'(w0), v1[5:0], u1[5:0], 3'(w1),
                          29'b0};
            else
                r.data = {5'b0, v1[5:0], u1[5:0], 3'(w1), v0[5:0], u0[5:0], 3'(w0),
                          29'b0};
        end else begin
            wa = int'(d[31:29]); wb = int'(d[46:44]);
            ua = 64'(d[37:32]); va = 64'(d[43:38]);
            ub = 64'(d[52:47]); vb = 64'(d[58:53]);
            if (wa == wb) return r;
            rev = wa > wb;
            if (rev) begin
                w0 = wb; a_u = ub; a_v = vb; w1 = wa; b_u = ua; b_v = va;
            end else begin
                w0 = wa; a_u = ua; a_v = va; w1 = wb; b_u = ub; b_v = vb;
            end
            if (w1 > 5) return r;
            acc = 0;
            for (j = w0 + 1; j < w1; j++) acc += 64'(wall_area(j));
            acc = acc * 64'(wall_area(w0)) + 64'(wall_base[w0]);
            acc += (64'(grid[axis_col(w0)]) * a_v + a_u) * 64'(wall_area(w1));
            acc += 64'(grid[axis_col(w1)]) * b_v + b_u;
            if (rev) acc += 64'(wall_base[5]) - 64'd1;
            r.ok   = 1'b1;
            r.data = {35'b0, acc[28:0]};
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_conv want;
        logic [6:0] v;
        if (!i_rst_n) begin
            grid = '{1, 1, 1};
            rebuild_bases();
            conv_queue.delete();
            fails <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index <= REG_GRID_Z) begin
                v = i_cfg_data;
                if (v < 1) v = 1;
                if (v > 64) v = 64;
                grid[i_cfg_index] = 32'(v);
                rebuild_bases();
            end
            if (i_s_tvalid && i_s_tready)
                conv_queue.push_back(convert_word(i_s_tuser, i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (conv_queue.size() == 0) begin
                    $display("%0t: unexpected word ok=%0b data=%h", $time, i_m_tuser,
                             i_m_tdata);
                    fails <= fails + 1;
                end else begin
                    want = conv_queue.pop_front();
                    if (want.ok !== i_m_tuser || want.data !== i_m_tdata) begin
                        $display("%0t: expected ok=%0b data=%h, got ok=%0b data=%h",
                                 $time, want.ok, want.data, i_m_tuser, i_m_tdata);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end

endmodule

>>> sim/beam_index_coordinate_convert_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// beam_index_coordinate_convert_test
// Drives configuration phases and decode and encode words into the converter
// with random idling on both streams; the checker predicts and compares.
// ----------------------------------------------------------------------------
module beam_index_coordinate_convert_test;
    import bicc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GRID_W-1:0]    cfg_data = '0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata = '0;
    logic                 s_tuser = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    int                   fail_count, pending, quiet;
    bit                   calm;
    logic [31:0]          index_span;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    beam_index_coordinate_convert dut (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser)
    );

    beam_index_coordinate_convert_checker check (
        .i_clk, .i_rst_n,
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls at random except during the calm stretch.
    always @(posedge i_clk)
        m_tready <= calm || ($urandom_range(99) >= 8);

    always @(posedge i_clk) begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Grid counts and their wall-pair span, mirrored here to aim decode indices.
    int gx = 1, gy = 1, gz = 1;

    function automatic int clamp_grid(int v);
        return (v < 1) ? 1 : (v > 64) ? 64 : v;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GRID_W-1:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge i_clk);
        if (idx == REG_GRID_X) gx = clamp_grid(int'(val));
        if (idx == REG_GRID_Y) gy = clamp_grid(int'(val));
        if (idx == REG_GRID_Z) gz = clamp_grid(int'(val));
    endtask

    task automatic apply_grid(logic [6:0] x, logic [6:0] y, logic [6:0] z);
        int a[6];
        logic [63:0] b5, acc;
        s_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        write_reg(REG_GRID_X, x);
        write_reg(REG_GRID_Y, y);
        write_reg(REG_GRID_Z, z);
        write_reg(2'd3, 7'($urandom));
        a = '{gy*gz, gy*gz, gz*gx, gz*gx, gx*gy, gx*gy};
        b5 = 1;
        for (int w = 1; w < 6; w++) begin
            acc = 0;
            for (int k = w; k < 6; k++) acc += 64'(a[k]);
            b5 += acc * 64'(a[w-1]);
        end
        index_span = 2 * (32'(b5[28:0]) - 32'd1);
    endtask

    task automatic send_word(logic action, logic [63:0] d);
        if (!calm)
            while ($urandom_range(99) < 8) begin
                s_tvalid <= 0;
                @(posedge i_clk);
            end
        s_tvalid <= 1; s_tuser <= action; s_tdata <= d;
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [63:0] pack_enc(int wa, int au, int av, int wb, int bu,
                                             int bv);
        return {5'b0, 6'(bv), 6'(bu), 3'(wb), 6'(av), 6'(au), 3'(wa), 29'b0};
    endfunction

    task automatic random_word();
        logic [63:0] d;
        int wa, wb, r;
        r = $urandom_range(99);
        if (r < 45) begin
            d = '0;
            if ($urandom_range(9) == 0) d[28:0] = 29'($urandom);
            else d[28:0] = 29'($urandom_range(index_span + 1));
            send_word(ACT_DECODE, d);
        end else begin
            wa = $urandom_range(5); wb = $urandom_range(5);
            if (r > 92) begin wa = $urandom_range(7); wb = $urandom_range(7); end
            if (r > 96) d = pack_enc(wa, $urandom_range(63), $urandom_range(63), wb,
                                     $urandom_range(63), $urandom_range(63));
            else d = pack_enc(wa, $urandom_range(64 - 1) %
                              ((wa < 2) ? gy : (wa < 4) ? gz : gx),
                              $urandom_range(63), wb, $urandom_range(63),
                              $urandom_range(63));
            d[58:53] = 6'(d[58:53] % ((wb < 2) ? gz : (wb < 4) ? gx : gy));
            d[52:47] = 6'(d[52:47] % ((wb < 2) ? gy : (wb < 4) ? gz : gx));
            d[43:38] = (r > 96) ? d[43:38]
                                : 6'(d[43:38] % ((wa < 2) ? gz : (wa < 4) ? gx : gy));
            send_word(ACT_ENCODE, d);
        end
    endtask

    initial begin
        calm = 0;
        index_span = 30;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset grid, both ends of the index range, bad walls.
        send_word(ACT_DECODE, 64'd0);
        send_word(ACT_DECODE, 64'd1);
        send_word(ACT_DECODE, 64'd15);
        send_word(ACT_DECODE, 64'd30);
        send_word(ACT_DECODE, 64'd31);
        send_word(ACT_DECODE, {35'b0, {29{1'b1}}});
        send_word(ACT_ENCODE, pack_enc(0, 0, 0, 5, 0, 0));
        send_word(ACT_ENCODE, pack_enc(5, 0, 0, 0, 0, 0));
        send_word(ACT_ENCODE, pack_enc(3, 0, 0, 3, 0, 0));
        send_word(ACT_ENCODE, pack_enc(6, 0, 0, 7, 0, 0));
        send_word(ACT_ENCODE, pack_enc(2, 0, 0, 7, 0, 0));
        send_word(ACT_ENCODE, pack_enc(0, 63, 63, 4, 63, 63));
        apply_grid(7'd64, 7'd64, 7'd64);
        send_word(ACT_DECODE, 64'd1);
        send_word(ACT_DECODE, {35'b0, 29'(index_span)});
        send_word(ACT_DECODE, {35'b0, 29'(index_span + 1)});
        send_word(ACT_ENCODE, pack_enc(4, 63, 63, 1, 63, 63));
        send_word(ACT_ENCODE, pack_enc(5, 63, 63, 4, 63, 63));
        apply_grid(7'd0, 7'd127, 7'd3);
        send_word(ACT_DECODE, {35'b0, 29'(index_span / 2)});
        send_word(ACT_ENCODE, pack_enc(1, 0, 2, 3, 0, 0));

        for (int phase = 0; phase < 9; phase++) begin
            case (phase % 3)
                0: apply_grid(7'($urandom_range(1, 4)), 7'($urandom_range(1, 4)),
                              7'($urandom_range(1, 4)));
                1: apply_grid(7'($urandom_range(1, 16)), 7'($urandom_range(1, 16)),
                              7'($urandom_range(1, 16)));
                default: apply_grid(7'($urandom_range(127)), 7'($urandom_range(127)),
                                    7'($urandom_range(127)));
            endcase
            calm = (phase == 4);
            for (int n = 0; n < 200; n++) random_word();
        end
        s_tvalid <= 0;
        calm = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
